// File: sv/tmb_pkg.sv
// ----------------------------------------------------------------------------
// tmb_pkg
// Shared types and constants for the TRS model matrix builder.
// ----------------------------------------------------------------------------
package tmb_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  typedef logic signed [33:0] q30_t;

  function automatic logic signed [33:0] atan_turn(input logic [4:0] idx);
    logic signed [33:0] v;
    begin
      case (idx)
        5'd0: v = 34'sh20000000;  5'd1: v = 34'sh12E4051E;
        5'd2: v = 34'sh09FB385B;  5'd3: v = 34'sh051111D4;
        5'd4: v = 34'sh028B0D43;  5'd5: v = 34'sh0145D7E1;
        5'd6: v = 34'sh00A2F61E;  5'd7: v = 34'sh00517C55;
        5'd8: v = 34'sh0028BE53;  5'd9: v = 34'sh00145F2F;
        5'd10: v = 34'sh000A2F98; 5'd11: v = 34'sh000517CC;
        5'd12: v = 34'sh00028BE6; 5'd13: v = 34'sh000145F3;
        5'd14: v = 34'sh0000A2FA; 5'd15: v = 34'sh0000517D;
        5'd16: v = 34'sh000028BE; 5'd17: v = 34'sh0000145F;
        5'd18: v = 34'sh00000A30; 5'd19: v = 34'sh00000518;
        5'd20: v = 34'sh0000028C; 5'd21: v = 34'sh00000146;
        5'd22: v = 34'sh000000A3; 5'd23: v = 34'sh00000051;
        5'd24: v = 34'sh00000029; 5'd25: v = 34'sh00000014;
        5'd26: v = 34'sh0000000A; 5'd27: v = 34'sh00000005;
        5'd28: v = 34'sh00000003; 5'd29: v = 34'sh00000001;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

  // Q30 product with round half up
  function automatic logic signed [33:0] mul_q30(input logic signed [33:0] a,
                                                  input logic signed [33:0] b);
    logic signed [67:0] p;
    begin
      p = a * b + 68'sd536870912;
      return p[63:30];
    end
  endfunction

  // scale product, saturated to 32 bits
  function automatic logic [31:0] mul_sat(input logic signed [33:0] r,
                                          input logic signed [31:0] s);
    logic signed [65:0] p;
    logic signed [35:0] q;
    begin
      p = r * s + 66'sd536870912;
      q = p[65:30];
      if (q > 36'sd2147483647) return 32'h7FFFFFFF;
      else if (q < -36'sd2147483648) return 32'h80000000;
      else return q[31:0];
    end
  endfunction

endpackage

// File: sv/tmb_in_if.sv
// ----------------------------------------------------------------------------
// tmb_in_if
// Input channel: pose beat.
// ----------------------------------------------------------------------------
interface tmb_in_if #(parameter int ANGLE_BITS = 16);
  logic valid;
  logic ready;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic [ANGLE_BITS-1:0] angle_x, angle_y, angle_z;
  logic signed [31:0] scale_x, scale_y, scale_z;
  modport source (output valid, pos_x, pos_y, pos_z, angle_x, angle_y, angle_z,
                  scale_x, scale_y, scale_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, angle_x, angle_y, angle_z,
                scale_x, scale_y, scale_z, output ready);
endinterface

// File: sv/tmb_out_if.sv
// ----------------------------------------------------------------------------
// tmb_out_if
// Output channel: one matrix column per beat.
// ----------------------------------------------------------------------------
interface tmb_out_if;
  logic valid;
  logic ready;
  logic [1:0] column_index;
  logic signed [31:0] row0_value, row1_value, row2_value, row3_value;
  logic last_column;
  modport source (output valid, column_index, row0_value, row1_value, row2_value,
                  row3_value, last_column, input ready);
  modport sink (input valid, column_index, row0_value, row1_value, row2_value,
                row3_value, last_column, output ready);
endinterface

// File: sv/tmb_cordic.sv
// ----------------------------------------------------------------------------
// tmb_cordic
// Pipelined rotation CORDIC, three angles in parallel, one step per stage.
// ----------------------------------------------------------------------------
module tmb_cordic #(
  parameter int ANGLE_BITS = 16,
  parameter int W = 100
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [ANGLE_BITS-1:0] ang [3],
  input  logic [W-1:0] side_in,
  output logic out_valid,
  output tmb_pkg::q30_t cs [3],
  output tmb_pkg::q30_t sn [3],
  output logic [W-1:0] side_out
);
  localparam int N = tmb_pkg::CORDIC_STEPS;

  // quadrant fold of the incoming angles
  tmb_pkg::q30_t z0 [3];
  logic [1:0] q0 [3];

  // stage k holds the rotation after k+1 steps
  tmb_pkg::q30_t x [N][3];
  tmb_pkg::q30_t y [N][3];
  tmb_pkg::q30_t z [N][3];
  logic [1:0] q [N][3];
  logic [W-1:0] side [N];
  logic vld [N];

  always_comb begin
    logic [31:0] t;
    logic [31:0] ru;
    logic [1:0] qq;
    for (int a = 0; a < 3; a++) begin
      t = {ang[a], {(32-ANGLE_BITS){1'b0}}};
      qq = 2'(((t + 32'h20000000) >> 30));
      ru = t - {qq, 30'd0};
      z0[a] = 34'(signed'(ru));
      q0[a] = qq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 1; i < N; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    tmb_pkg::q30_t xi, yi, zi;
    if (en) begin
      side[0] <= side_in;
      for (int i = 1; i < N; i++) side[i] <= side[i-1];
      for (int a = 0; a < 3; a++) begin
        q[0][a] <= q0[a];
        for (int i = 1; i < N; i++) q[i][a] <= q[i-1][a];
        for (int i = 0; i < N; i++) begin
          if (i == 0) begin
            xi = tmb_pkg::CORDIC_GAIN;
            yi = '0;
            zi = z0[a];
          end else begin
            xi = x[i-1][a];
            yi = y[i-1][a];
            zi = z[i-1][a];
          end
          if (!zi[33]) begin
            x[i][a] <= xi - (yi >>> i);
            y[i][a] <= yi + (xi >>> i);
            z[i][a] <= zi - tmb_pkg::atan_turn(5'(i));
          end else begin
            x[i][a] <= xi + (yi >>> i);
            y[i][a] <= yi - (xi >>> i);
            z[i][a] <= zi + tmb_pkg::atan_turn(5'(i));
          end
        end
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      case (q[N-1][a])
        2'd0: begin cs[a] = x[N-1][a];  sn[a] = y[N-1][a];  end
        2'd1: begin cs[a] = -y[N-1][a]; sn[a] = x[N-1][a];  end
        2'd2: begin cs[a] = -x[N-1][a]; sn[a] = -y[N-1][a]; end
        default: begin cs[a] = y[N-1][a]; sn[a] = -x[N-1][a]; end
      endcase
    end
  end
  assign out_valid = vld[N-1];
  assign side_out = side[N-1];
endmodule

// File: sv/tmb_rot.sv
// ----------------------------------------------------------------------------
// tmb_rot
// Rotation matrix from sines and cosines, three product stages.
// ----------------------------------------------------------------------------
module tmb_rot #(
  parameter int W = 100
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  tmb_pkg::q30_t cs [3],
  input  tmb_pkg::q30_t sn [3],
  input  logic [W-1:0] side_in,
  output logic out_valid,
  output tmb_pkg::q30_t r [9],
  output logic [W-1:0] side_out
);
  // stage 1 regs
  tmb_pkg::q30_t zy_x, sy_z, p_szcx, p_szsx, p_czcx, p_czsx;
  tmb_pkg::q30_t r00a, r10a, r20a, r21a, r22a, cx1, sx1;
  logic v1, v2;
  logic [W-1:0] s1, s2;
  // stage 2 regs
  tmb_pkg::q30_t a01, a02, a11, a12;
  tmb_pkg::q30_t b01, b02, b11, b12, r00b, r10b, r20b, r21b, r22b;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid; v2 <= v1; out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zy_x <= tmb_pkg::mul_q30(cs[2], sn[1]);
      sy_z <= tmb_pkg::mul_q30(sn[2], sn[1]);
      p_szcx <= tmb_pkg::mul_q30(sn[2], cs[0]);
      p_szsx <= tmb_pkg::mul_q30(sn[2], sn[0]);
      p_czcx <= tmb_pkg::mul_q30(cs[2], cs[0]);
      p_czsx <= tmb_pkg::mul_q30(cs[2], sn[0]);
      r00a <= tmb_pkg::mul_q30(cs[2], cs[1]);
      r10a <= tmb_pkg::mul_q30(sn[2], cs[1]);
      r20a <= -sn[1];
      r21a <= tmb_pkg::mul_q30(cs[1], sn[0]);
      r22a <= tmb_pkg::mul_q30(cs[1], cs[0]);
      cx1 <= cs[0]; sx1 <= sn[0];
      s1 <= side_in;

      a01 <= tmb_pkg::mul_q30(zy_x, sx1);
      a02 <= tmb_pkg::mul_q30(zy_x, cx1);
      a11 <= tmb_pkg::mul_q30(sy_z, sx1);
      a12 <= tmb_pkg::mul_q30(sy_z, cx1);
      b01 <= p_szcx; b02 <= p_szsx; b11 <= p_czcx; b12 <= p_czsx;
      r00b <= r00a; r10b <= r10a; r20b <= r20a; r21b <= r21a; r22b <= r22a;
      s2 <= s1;

      r[0] <= r00b; r[1] <= a01 - b01; r[2] <= a02 + b02;
      r[3] <= r10b; r[4] <= a11 + b11; r[5] <= a12 - b12;
      r[6] <= r20b; r[7] <= r21b;      r[8] <= r22b;
      side_out <= s2;
    end
  end
endmodule

// File: sv/trs_model_matrix_builder.sv
// ----------------------------------------------------------------------------
// trs_model_matrix_builder
// Builds the model matrix T*Rz*Ry*Rx*S and streams it out column by column.
// ----------------------------------------------------------------------------
// Usage:
//   in  : one beat per transform (position, binary angles, per-axis scale).
//   out : four beats per transform, columns 0..3; last_column marks column 3.
//   Columns 0-2 are the rotation columns times scale, row 3 zero; column 3 is
//   the position with one in row 3.
// Throughput: the single output port serializes the four columns of each
//   transform, and the next transform is taken only as the last column is
//   released; the compute pipeline itself takes a beat every cycle when not stalled.
// Stages: 30 CORDIC stages + 3 product stages + 1 scale stage that doubles
//   as the output register from which the columns are driven.
// Reset: synchronous, clears all valid bits; no state beyond the pipeline.
// Stall: the whole pipeline freezes while the column serializer holds a
//   transform whose last column is not yet accepted; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module trs_model_matrix_builder #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS = 16
) (
  input logic clk,
  input logic rst,
  tmb_in_if.sink in,
  tmb_out_if.source out
);
  // side payload: pos (96) + scale (96)
  localparam int W = 192;

  logic en;
  logic [ANGLE_BITS-1:0] ang [3];
  logic cv, rv;
  tmb_pkg::q30_t cs [3];
  tmb_pkg::q30_t sn [3];
  tmb_pkg::q30_t r [9];
  logic [W-1:0] cside, rside;

  // final stage: scaled columns held for the serializer
  logic hv;
  logic [31:0] col [3][3];
  logic [31:0] pos [3];
  logic [1:0] idx;

  logic done_last;
  assign done_last = out.valid && out.ready && idx == 2'd3;
  // pipeline moves when holding stage is empty or releasing its last column
  assign en = !hv || done_last;
  assign in.ready = en;

  assign ang[0] = in.angle_x;
  assign ang[1] = in.angle_y;
  assign ang[2] = in.angle_z;

  tmb_cordic #(.ANGLE_BITS(ANGLE_BITS), .W(W)) u_cordic (
    .clk, .rst, .en,
    .in_valid(in.valid && in.ready),
    .ang,
    .side_in({in.pos_x, in.pos_y, in.pos_z, in.scale_x, in.scale_y, in.scale_z}),
    .out_valid(cv), .cs, .sn, .side_out(cside)
  );

  tmb_rot #(.W(W)) u_rot (
    .clk, .rst, .en, .in_valid(cv), .cs, .sn, .side_in(cside),
    .out_valid(rv), .r, .side_out(rside)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hv <= 1'b0;
      idx <= '0;
    end else begin
      if (en) begin
        hv <= rv;
        idx <= '0;
      end else if (out.valid && out.ready) begin
        idx <= idx + 2'd1;
      end
    end
  end

  // scale multiply per column
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          col[j][i] <= tmb_pkg::mul_sat(r[i*3+j], rside[95-32*j -: 32]);
        end
        pos[j] <= rside[191-32*j -: 32];
      end
    end
  end

  assign out.valid = hv;
  assign out.column_index = idx;
  assign out.last_column = idx == 2'd3;
  always_comb begin
    if (idx == 2'd3) begin
      out.row0_value = pos[0];
      out.row1_value = pos[1];
      out.row2_value = pos[2];
      out.row3_value = 32'(64'd1 << FRAC_BITS);
    end else begin
      out.row0_value = col[idx][0];
      out.row1_value = col[idx][1];
      out.row2_value = col[idx][2];
      out.row3_value = '0;
    end
  end
endmodule
